>>> rtl/b64e_pkg.sv
// Shared types, character constants and the alphabet lookup for the Base64 line-wrap encoder.
`default_nettype none

package b64e_pkg;

    localparam int CHAR_W      = 8;
    localparam int GPL_W       = 6;
    localparam int GRP_CHARS   = 6;
    localparam int CNT_W       = 3;

    localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'd10;
    localparam logic [CHAR_W-1:0] CH_PAD = 8'd61;

    localparam logic [GPL_W-1:0] GPL_RESET = 6'd19;

    localparam logic REG_GROUPS_PER_LINE = 1'b0;

    localparam logic [1:0] PHASE_EMPTY = 2'd0;
    localparam logic [1:0] PHASE_ONE   = 2'd1;
    localparam logic [1:0] PHASE_TWO   = 2'd2;

    typedef struct packed {
        logic [GRP_CHARS-1:0][CHAR_W-1:0] chars;
        logic [CNT_W-1:0]                 count;
        logic                             last;
    } group_t;

    function automatic logic [CHAR_W-1:0] sextet(input logic [5:0] v);
        logic [CHAR_W-1:0] c;
        begin
            if (v < 6'd26)
                c = 8'd65 + {2'b00, v};
            else if (v < 6'd52)
                c = 8'd97 + {2'b00, v} - 8'd26;
            else if (v < 6'd62)
                c = 8'd48 + {2'b00, v} - 8'd52;
            else if (v == 6'd62)
                c = 8'd43;
            else
                c = 8'd47;
            return c;
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/b64e_cfg.sv
// Configuration register file holding the groups-per-line setting.
`default_nettype none

module b64e_cfg
    import b64e_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [2:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic      [31:0]      prdata,
    output logic                  pready,
    output logic      [GPL_W-1:0] groups_per_line
);

    logic [GPL_W-1:0] gpl_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign groups_per_line = gpl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gpl_reg <= GPL_RESET;
        else if (wr_en && (paddr[2] == REG_GROUPS_PER_LINE))
            gpl_reg <= pwdata[GPL_W-1:0];
    end

    always_comb
    begin
        prdata = 32'd0;
        unique case (paddr[2])
            REG_GROUPS_PER_LINE: prdata = {{(32-GPL_W){1'b0}}, gpl_reg};
            default:             prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/b64e_pack.sv
// Input register, group state and character generation for one byte.
`default_nettype none

module b64e_pack
    import b64e_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [CHAR_W-1:0] s_tdata,
    input  wire logic              s_tlast,
    input  wire logic [GPL_W-1:0]  groups_per_line,
    input  wire logic              buf_free,
    output logic                   grp_valid,
    output group_t                 grp
);

    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_byte_reg;
    logic              in_last_reg;

    logic [CHAR_W-1:0] b1_reg, b1_next;
    logic [CHAR_W-1:0] b2_reg, b2_next;
    logic [1:0]        phase_reg, phase_next;
    logic [GPL_W-1:0]  gol_reg, gol_next;

    logic              advance;
    logic [GPL_W-1:0]  gol_inc;
    logic [CHAR_W-1:0] b;

    assign s_tready  = !in_valid_reg || buf_free;
    assign advance   = in_valid_reg && buf_free;
    assign grp_valid = in_valid_reg;
    assign b         = in_byte_reg;
    assign gol_inc   = gol_reg + 6'd1;

    always_comb
    begin
        b1_next    = b1_reg;
        b2_next    = b2_reg;
        phase_next = phase_reg;
        gol_next   = gol_reg;
        grp.chars  = '0;
        grp.count  = '0;
        grp.last   = in_last_reg;

        case (phase_reg)
            PHASE_EMPTY:
            begin
                b1_next    = b;
                phase_next = PHASE_ONE;
            end
            PHASE_ONE:
            begin
                b2_next    = b;
                phase_next = PHASE_TWO;
            end
            default:
            begin
                grp.chars[0] = sextet(b1_reg[7:2]);
                grp.chars[1] = sextet({b1_reg[1:0], b2_reg[7:4]});
                grp.chars[2] = sextet({b2_reg[3:0], b[7:6]});
                grp.chars[3] = sextet(b[5:0]);
                grp.count    = 3'd4;
                phase_next   = PHASE_EMPTY;
                b1_next      = '0;
                b2_next      = '0;
                if (groups_per_line != '0)
                begin
                    if (gol_inc >= groups_per_line || gol_inc == '0)
                    begin
                        grp.chars[4] = CH_CR;
                        grp.chars[5] = CH_LF;
                        grp.count    = 3'd6;
                        gol_next     = '0;
                    end
                    else
                    begin
                        gol_next = gol_inc;
                    end
                end
                else
                begin
                    gol_next = '0;
                end
            end
        endcase

        if (in_last_reg)
        begin
            if (phase_reg == PHASE_EMPTY)
            begin
                grp.chars[0] = sextet(b[7:2]);
                grp.chars[1] = sextet({b[1:0], 4'b0000});
                grp.chars[2] = CH_PAD;
                grp.chars[3] = CH_PAD;
                grp.count    = 3'd4;
            end
            else if (phase_reg == PHASE_ONE)
            begin
                grp.chars[0] = sextet(b1_reg[7:2]);
                grp.chars[1] = sextet({b1_reg[1:0], b[7:4]});
                grp.chars[2] = sextet({b[3:0], 2'b00});
                grp.chars[3] = CH_PAD;
                grp.count    = 3'd4;
            end
            b1_next    = '0;
            b2_next    = '0;
            phase_next = PHASE_EMPTY;
            gol_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            b1_reg       <= '0;
            b2_reg       <= '0;
            phase_reg    <= PHASE_EMPTY;
            gol_reg      <= '0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
            begin
                b1_reg    <= b1_next;
                b2_reg    <= b2_next;
                phase_reg <= phase_next;
                gol_reg   <= gol_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

endmodule

`default_nettype wire

>>> rtl/b64e_serial.sv
// Result buffer that sends the characters of one group out one beat per cycle while the output is ready.
`default_nettype none

module b64e_serial
    import b64e_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              grp_valid,
    input  wire group_t            grp,
    output logic                   buf_free,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [CHAR_W-1:0] m_tdata,
    output logic                   m_tlast
);

    logic [GRP_CHARS-1:0][CHAR_W-1:0] chars_reg;
    logic [CNT_W-1:0]                 count_reg;
    logic                             last_reg;
    logic                             pop;
    logic                             load;

    assign m_tvalid = (count_reg != '0);
    assign pop      = m_tvalid && m_tready;
    assign buf_free = (count_reg == '0) || (count_reg == 3'd1 && pop);
    assign load     = grp_valid && buf_free;
    assign m_tdata  = chars_reg[0];
    assign m_tlast  = last_reg && (count_reg == 3'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            last_reg  <= 1'b0;
        end
        else if (load)
        begin
            count_reg <= grp.count;
            last_reg  <= grp.last;
        end
        else if (pop)
        begin
            count_reg <= count_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            chars_reg <= grp.chars;
        end
        else if (pop)
        begin
            for (int i = 0; i < GRP_CHARS - 1; i++)
                chars_reg[i] <= chars_reg[i+1];
        end
    end

endmodule

`default_nettype wire

>>> rtl/base64_encoder_line_wrap.sv
// Top level of the streaming Base64 encoder with CR LF line wrapping.
//
//   Channel  Direction  Payload
//   s_*      in         tdata[7:0] = in_byte, tlast = last_byte
//   m_*      out        tdata[7:0] = out_char, tlast = last_char
//   APB      in/out     register 0 at address 0: groups_per_line[5:0]
//
// A byte beat is taken every cycle while the result buffer is free; a byte that
// closes no group only updates the group state as it leaves the input register.
// A completed group leaves as four beats, six with CR LF, one per cycle while
// the output is ready, and the next byte waits in the input register until the
// final beat goes. The first character is offered once the byte that closes its
// group has passed the input register and been loaded into the result buffer.
// Reset clears the group state and sets groups_per_line to 19. A stalled output
// holds the buffer, and the input register then holds its byte.
`default_nettype none

module base64_encoder_line_wrap
    import b64e_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // in_byte[7:0]
    input  wire logic         s_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic      [7:0]   m_tdata,   // out_char[7:0]
    output logic              m_tlast,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready
);

    logic [GPL_W-1:0] groups_per_line;
    logic             buf_free;
    logic             grp_valid;
    group_t           grp;

    b64e_cfg u_cfg (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .groups_per_line (groups_per_line)
    );

    b64e_pack u_pack (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .groups_per_line (groups_per_line),
        .buf_free        (buf_free),
        .grp_valid       (grp_valid),
        .grp             (grp)
    );

    b64e_serial u_serial (
        .clk       (clk),
        .rst_n     (rst_n),
        .grp_valid (grp_valid),
        .grp       (grp),
        .buf_free  (buf_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
